@@ rtl/mktd_pkg.sv @@
// Shared types, constants and the Morse code table for the key timing decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package mktd_pkg;

    localparam int TIMER_W         = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int MAX_TEXT_DEF    = 32;
    localparam int LETTER_COUNT    = 26;
    localparam int LETTER_W        = 7;
    localparam int HELD_W          = 5;
    localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd65;
    localparam logic [TIMER_W-1:0]  TIMER_MAX   = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_GAP = 3'd4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd30;
    localparam logic [CFG_W-1:0] DOT_MAX_RST   = 16'd200;
    localparam logic [CFG_W-1:0] DASH_MAX_RST  = 16'd600;
    localparam logic [CFG_W-1:0] CHAR_GAP_RST  = 16'd700;
    localparam logic [CFG_W-1:0] BLANK_GAP_RST = 16'd5000;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LETTER  = 3'd3,
        EV_ERROR   = 3'd4,
        EV_CLEAR   = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        SYM_NONE = 2'd0,
        SYM_DOT  = 2'd1,
        SYM_DASH = 2'd2
    } sym_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] dot_max;
        logic [CFG_W-1:0] dash_max;
        logic [CFG_W-1:0] char_gap;
        logic [CFG_W-1:0] blank_gap;
    } cfg_t;

    typedef struct packed {
        event_t              event_kind;
        sym_t                symbol_kind;
        logic [LETTER_W-1:0] letter_code;
        logic [HELD_W-1:0]   symbols_held;
        logic                first_of_character;
        logic                first_of_text;
        logic                key_active;
    } result_t;

    // symbol i sits in bit i, 1 for dash
    localparam logic [3:0] CODE_PAT [LETTER_COUNT] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14,
        4'd5, 4'd2, 4'd3, 4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1,
        4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3};
    localparam logic [2:0] CODE_LEN [LETTER_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4};

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        return (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
    endfunction

    // ASCII letter for the first n symbols, 0 when no pattern matches
    function automatic logic [LETTER_W-1:0] decode_letter(input logic [3:0] bits,
                                                           input logic [HELD_W-1:0] n);
        logic [3:0]          mask;
        logic [LETTER_W-1:0] letter;
        letter = '0;
        mask = (n >= 5'd4) ? 4'hF : 4'((5'd1 << n) - 5'd1);
        for (int k = 0; k < LETTER_COUNT; k++)
        begin
            if ((n == HELD_W'(CODE_LEN[k])) && ((bits & mask) == CODE_PAT[k]))
            begin
                letter = letter | (LETTER_BASE + LETTER_W'(k));
            end
        end
        return letter;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mktd_cfg.sv @@
// Timing threshold registers written through the plain write port.
// Depends on mktd_pkg.
`default_nettype none

module mktd_cfg
    import mktd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:  cfg_next.debounce  = cfg_data;
                REG_DOT_MAX:   cfg_next.dot_max   = cfg_data;
                REG_DASH_MAX:  cfg_next.dash_max  = cfg_data;
                REG_CHAR_GAP:  cfg_next.char_gap  = cfg_data;
                REG_BLANK_GAP: cfg_next.blank_gap = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce  <= DEBOUNCE_RST;
            cfg_reg.dot_max   <= DOT_MAX_RST;
            cfg_reg.dash_max  <= DASH_MAX_RST;
            cfg_reg.char_gap  <= CHAR_GAP_RST;
            cfg_reg.blank_gap <= BLANK_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/mktd_core.sv @@
// Input tick register, key/gap timers, symbol store and decode logic.
// Depends on mktd_pkg.
`default_nettype none

module mktd_core
    import mktd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic key_down,
    input  wire logic res_ready,
    output logic      res_valid,
    output result_t   res
);

    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int TEXT_W = $clog2(MAX_TEXT + 1);

    logic                s1_valid_reg;
    logic                key_reg;
    logic                held_reg,  held_next;
    logic [TIMER_W-1:0]  press_reg, press_next;
    logic [TIMER_W-1:0]  gap_reg,   gap_next;
    logic [MAX_SYMBOLS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TEXT_W-1:0]   text_reg,  text_next;

    logic               in_fire;
    logic               s1_fire;
    logic [TIMER_W-1:0] press_len;
    logic [TIMER_W-1:0] gap_inc;
    logic [LETTER_W-1:0] letter;
    logic               store_free;
    sym_t               sym;

    assign s1_fire  = s1_valid_reg && res_ready;
    assign in_stall = s1_valid_reg && !res_ready;
    assign in_fire  = in_valid && !in_stall;

    assign press_len  = sat_inc(press_reg);
    assign gap_inc    = sat_inc(gap_reg);
    assign store_free = count_reg < CNT_W'(MAX_SYMBOLS);
    assign letter     = decode_letter(bits_reg[3:0], HELD_W'(count_reg));

    always_comb
    begin
        if ((press_len > cfg.debounce) && (press_len <= cfg.dot_max))
            sym = SYM_DOT;
        else if ((press_len > cfg.dot_max) && (press_len <= cfg.dash_max))
            sym = SYM_DASH;
        else
            sym = SYM_NONE;
    end

    always_comb
    begin
        held_next  = held_reg;
        press_next = press_reg;
        gap_next   = gap_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        text_next  = text_reg;
        res        = '0;
        res.event_kind  = EV_NONE;
        res.symbol_kind = SYM_NONE;

        priority if (key_reg && !held_reg)
        begin
            gap_next = gap_inc;
            if (store_free)
            begin
                held_next      = 1'b1;
                press_next     = '0;
                res.event_kind = EV_PRESS;
            end
        end
        else if (key_reg)
        begin
            gap_next   = gap_inc;
            press_next = sat_inc(press_reg);
        end
        else if (held_reg)
        begin
            held_next              = 1'b0;
            gap_next               = '0;
            res.event_kind         = EV_RELEASE;
            res.first_of_character = (count_reg == '0);
            res.symbol_kind        = sym;
            if ((sym != SYM_NONE) && store_free)
            begin
                if (sym == SYM_DASH)
                    bits_next = bits_reg | (MAX_SYMBOLS'(1) << count_reg);
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            gap_next = gap_inc;
            if ((gap_inc >= cfg.char_gap) && (count_reg != '0))
            begin
                if (letter != '0)
                begin
                    res.event_kind    = EV_LETTER;
                    res.letter_code   = letter;
                    res.first_of_text = (text_reg == '0);
                    if (text_reg < TEXT_W'(MAX_TEXT))
                        text_next = text_reg + 1'b1;
                end
                else
                begin
                    res.event_kind = EV_ERROR;
                end
                bits_next  = '0;
                count_next = '0;
                gap_next   = '0;
            end
            else if ((gap_inc >= cfg.blank_gap) && (text_reg != '0))
            begin
                res.event_kind = EV_CLEAR;
                text_next      = '0;
                bits_next      = '0;
                count_next     = '0;
            end
        end

        res.symbols_held = HELD_W'(count_next);
        res.key_active   = held_next;
    end

    assign res_valid = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            held_reg     <= 1'b0;
            press_reg    <= '0;
            gap_reg      <= '0;
            bits_reg     <= '0;
            count_reg    <= '0;
            text_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
            begin
                held_reg  <= held_next;
                press_reg <= press_next;
                gap_reg   <= gap_next;
                bits_reg  <= bits_next;
                count_reg <= count_next;
                text_reg  <= text_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            key_reg <= key_down;
    end

endmodule

`default_nettype wire

@@ rtl/mktd_out.sv @@
// Result register between the decode logic and the output channel.
// Depends on mktd_pkg.
`default_nettype none

module mktd_out
    import mktd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         res_ready,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_res
);

    logic    valid_reg;
    result_t res_reg;

    // load whenever the register is empty or its transfer completes now
    assign res_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_ready)
            valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ rtl/morse_key_timing_decoder.sv @@
// Morse straight-key timing decoder, one key sample per tick item.
// out_valid follows the input transfer through the input register and then the result register.
// Throughput: one tick per cycle while out_stall is low; a tick's timers and decode settle in one pass.
// Reset (rst_n low, async): pipeline empty, timers, symbol store and text count zero,
// thresholds back to 30/200/600/700/5000 ticks.
// Depends on mktd_pkg, mktd_cfg, mktd_core, mktd_out.
`default_nettype none

module morse_key_timing_decoder
    import mktd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 key_down,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                event_kind,
    output logic [1:0]                symbol_kind,
    output logic [LETTER_W-1:0]       letter_code,
    output logic [HELD_W-1:0]         symbols_held,
    output logic                      first_of_character,
    output logic                      first_of_text,
    output logic                      key_active
);

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    res_valid;
    logic    res_ready;

    mktd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mktd_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .MAX_TEXT    (MAX_TEXT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_down  (key_down),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    mktd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign event_kind         = out_res.event_kind;
    assign symbol_kind        = out_res.symbol_kind;
    assign letter_code        = out_res.letter_code;
    assign symbols_held       = out_res.symbols_held;
    assign first_of_character = out_res.first_of_character;
    assign first_of_text      = out_res.first_of_text;
    assign key_active         = out_res.key_active;

endmodule

`default_nettype wire

@@ rtl/mktd_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on mktd_pkg and morse_key_timing_decoder.
`default_nettype none

module mktd_port_checks
    import mktd_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [2:0]          event_kind,
    input wire logic [1:0]          symbol_kind,
    input wire logic [LETTER_W-1:0] letter_code,
    input wire logic                first_of_character,
    input wire logic                first_of_text,
    input wire logic                key_active
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_LETTER |-> letter_code >= 7'd65 && letter_code <= 7'd90)
        else $error("letter event without an A..Z code");

    a_letter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_LETTER |-> letter_code == '0 && !first_of_text)
        else $error("letter fields set outside a letter event");

    a_release_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_RELEASE |-> symbol_kind == SYM_NONE && !first_of_character)
        else $error("release fields set outside a release event");

    a_press_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_PRESS || event_kind == EV_RELEASE)
            |-> key_active == (event_kind == EV_PRESS))
        else $error("key_active disagrees with press or release");

endmodule

bind morse_key_timing_decoder mktd_port_checks u_mktd_port_checks (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .event_kind         (event_kind),
    .symbol_kind        (symbol_kind),
    .letter_code        (letter_code),
    .first_of_character (first_of_character),
    .first_of_text      (first_of_text),
    .key_active         (key_active)
);

`default_nettype wire

@@ tb/sv/mktd_checker.sv @@
// Result checker for the Morse key timing decoder: models the decoder per tick and
// compares every output transfer against the oldest predicted result.
// Depends on mktd_pkg (types, register indexes, reset thresholds).

module mktd_checker
    import mktd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 key_down,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           event_kind,
    input  logic [1:0]           symbol_kind,
    input  logic [LETTER_W-1:0]  letter_code,
    input  logic [HELD_W-1:0]    symbols_held,
    input  logic                 first_of_character,
    input  logic                 first_of_text,
    input  logic                 key_active,
    output int                   pending,
    output int                   mismatches,
    output int                   ticks_seen,
    output int                   letters_seen,
    output int                   bad_chars_seen,
    output int                   clears_seen
);

    localparam int SYMBOL_CAP = MAX_SYMBOLS_DEF;
    localparam int TEXT_CAP   = MAX_TEXT_DEF;

    // dot/dash spelling of A..Z
    string morse_spelling [LETTER_COUNT] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--.."};

    cfg_t                timing;
    logic                pressed;
    logic [TIMER_W-1:0]  press_ticks;
    logic [TIMER_W-1:0]  gap_ticks;
    logic [15:0]         sym_bits;
    logic [HELD_W-1:0]   sym_count;
    logic [5:0]          text_len;
    result_t             due_results [$];
    int                  results_seen;

    function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] t);
        if (t == TIMER_MAX)
            return t;
        return t + 1'b1;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(input logic [15:0] bits, input int n);
        string pat;
        pat = "";
        if (n < 1 || n > 4)
            return '0;
        for (int i = 0; i < n; i++)
            pat = {pat, bits[i] ? "-" : "."};
        for (int k = 0; k < LETTER_COUNT; k++)
        begin
            if (pat == morse_spelling[k])
                return LETTER_W'(65 + k);
        end
        return '0;
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 50)
            $display("mktd_checker: result %0d %s got %0d want %0d", results_seen, what, got,
                     want);
    endtask

    // one key tick through the decoder state
    task automatic decode_tick(input logic key, output result_t r);
        logic [TIMER_W-1:0]  len;
        event_t              ev;
        sym_t                sym;
        logic [LETTER_W-1:0] letter;
        logic                fc;
        logic                ft;
        ev = EV_NONE;
        sym = SYM_NONE;
        letter = '0;
        fc = 1'b0;
        ft = 1'b0;
        if (key && !pressed)
        begin
            gap_ticks = bump(gap_ticks);
            // full store: press ignored, gap keeps running
            if (sym_count < SYMBOL_CAP)
            begin
                pressed = 1'b1;
                press_ticks = '0;
                ev = EV_PRESS;
            end
        end
        else if (key)
        begin
            gap_ticks = bump(gap_ticks);
            press_ticks = bump(press_ticks);
        end
        else if (pressed)
        begin
            len = bump(press_ticks);
            pressed = 1'b0;
            gap_ticks = '0;
            ev = EV_RELEASE;
            fc = (sym_count == 0);
            if (len > timing.debounce && len <= timing.dot_max)
                sym = SYM_DOT;
            else if (len > timing.dot_max && len <= timing.dash_max)
                sym = SYM_DASH;
            if (sym != SYM_NONE && sym_count < SYMBOL_CAP)
            begin
                if (sym == SYM_DASH)
                    sym_bits[sym_count] = 1'b1;
                sym_count = sym_count + 1'b1;
            end
        end
        else
        begin
            gap_ticks = bump(gap_ticks);
            // decode wins over clear on the same tick
            if (gap_ticks >= timing.char_gap && sym_count > 0)
            begin
                letter = letter_of(sym_bits, int'(sym_count));
                if (letter != 0)
                begin
                    ev = EV_LETTER;
                    ft = (text_len == 0);
                    if (text_len < TEXT_CAP)
                        text_len = text_len + 1'b1;
                end
                else
                    ev = EV_ERROR;
                sym_bits = '0;
                sym_count = '0;
                gap_ticks = '0;
            end
            else if (gap_ticks >= timing.blank_gap && text_len > 0)
            begin
                ev = EV_CLEAR;
                text_len = '0;
                sym_bits = '0;
                sym_count = '0;
            end
        end
        r.event_kind = ev;
        r.symbol_kind = sym;
        r.letter_code = letter;
        r.symbols_held = sym_count;
        r.first_of_character = fc;
        r.first_of_text = ft;
        r.key_active = pressed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t r;
        result_t head;
        if (!rst_n)
        begin
            timing.debounce = DEBOUNCE_RST;
            timing.dot_max = DOT_MAX_RST;
            timing.dash_max = DASH_MAX_RST;
            timing.char_gap = CHAR_GAP_RST;
            timing.blank_gap = BLANK_GAP_RST;
            pressed = 1'b0;
            press_ticks = '0;
            gap_ticks = '0;
            sym_bits = '0;
            sym_count = '0;
            text_len = '0;
            due_results.delete();
            results_seen = 0;
            mismatches = 0;
            ticks_seen = 0;
            letters_seen = 0;
            bad_chars_seen = 0;
            clears_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (due_results.size() == 0)
                    report("transfer with no tick pending, event_kind", event_kind, 0);
                else
                begin
                    head = due_results.pop_front();
                    if (event_kind !== head.event_kind)
                        report("event_kind", event_kind, head.event_kind);
                    if (symbol_kind !== head.symbol_kind)
                        report("symbol_kind", symbol_kind, head.symbol_kind);
                    if (letter_code !== head.letter_code)
                        report("letter_code", letter_code, head.letter_code);
                    if (symbols_held !== head.symbols_held)
                        report("symbols_held", symbols_held, head.symbols_held);
                    if (first_of_character !== head.first_of_character)
                        report("first_of_character", first_of_character,
                               head.first_of_character);
                    if (first_of_text !== head.first_of_text)
                        report("first_of_text", first_of_text, head.first_of_text);
                    if (key_active !== head.key_active)
                        report("key_active", key_active, head.key_active);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE:  timing.debounce = cfg_data;
                    REG_DOT_MAX:   timing.dot_max = cfg_data;
                    REG_DASH_MAX:  timing.dash_max = cfg_data;
                    REG_CHAR_GAP:  timing.char_gap = cfg_data;
                    REG_BLANK_GAP: timing.blank_gap = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                decode_tick(key_down, r);
                due_results.push_back(r);
                ticks_seen++;
                if (r.event_kind == EV_LETTER)
                    letters_seen++;
                if (r.event_kind == EV_ERROR)
                    bad_chars_seen++;
                if (r.event_kind == EV_CLEAR)
                    clears_seen++;
            end
            pending <= due_results.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the key timing decoder testbench: clock, reset, key tick stimulus, threshold
// settings and output pacing; mktd_checker does the prediction and comparison.
// Depends on mktd_pkg, morse_key_timing_decoder and mktd_checker.

module tb_top;
    import mktd_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int HOLD_OFF    = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 key_down = 1'b0;
    logic                 out_stall = 1'b0;
    logic                 want_hold = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic [2:0]           event_kind;
    logic [1:0]           symbol_kind;
    logic [LETTER_W-1:0]  letter_code;
    logic [HELD_W-1:0]    symbols_held;
    logic                 first_of_character;
    logic                 first_of_text;
    logic                 key_active;

    int pending;
    int mismatches;
    int ticks_seen;
    int letters_seen;
    int bad_chars_seen;
    int clears_seen;

    int cycles = 0;
    int burst_left = 0;
    int ticks_sent = 0;
    int settings_used = 0;
    int cur_deb = DEBOUNCE_RST;
    int cur_dot = DOT_MAX_RST;
    int cur_dash = DASH_MAX_RST;
    int cur_cg = CHAR_GAP_RST;
    int cur_bg = BLANK_GAP_RST;

    int  rx_hold_left = 0;
    int  rx_seg_left = 0;
    int  rx_seg_kind = 0;
    bit  rx_hold_done = 1'b0;

    morse_key_timing_decoder dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .key_down           (key_down),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .event_kind         (event_kind),
        .symbol_kind        (symbol_kind),
        .letter_code        (letter_code),
        .symbols_held       (symbols_held),
        .first_of_character (first_of_character),
        .first_of_text      (first_of_text),
        .key_active         (key_active)
    );

    mktd_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .key_down           (key_down),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .event_kind         (event_kind),
        .symbol_kind        (symbol_kind),
        .letter_code        (letter_code),
        .symbols_held       (symbols_held),
        .first_of_character (first_of_character),
        .first_of_text      (first_of_text),
        .key_active         (key_active),
        .pending            (pending),
        .mismatches         (mismatches),
        .ticks_seen         (ticks_seen),
        .letters_seen       (letters_seen),
        .bad_chars_seen     (bad_chars_seen),
        .clears_seen        (clears_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: cycle limit reached with %0d results pending", pending);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // output pacing: random stall segments, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else if (want_hold && !rx_hold_done)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_OFF;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_seg_left == 0)
            begin
                rx_seg_kind = $urandom_range(0, 2);
                rx_seg_left = $urandom_range(1, 64);
            end
            rx_seg_left--;
            case (rx_seg_kind)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // n ticks at one key level, sent in bursts with random gaps
    task automatic key_run(input logic level, input int n);
        int gap;
        repeat (n)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            in_valid <= 1'b1;
            key_down <= level;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            burst_left--;
            ticks_sent++;
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timing(input int deb, input int dot, input int dash, input int cg,
                              input int bg);
        logic [CFG_IDX_W-1:0] idx_list [8];
        logic [CFG_W-1:0]     data_list [8];
        drain();
        // the last three slots hit unused indexes with junk data
        idx_list = '{REG_DEBOUNCE, REG_DOT_MAX, REG_DASH_MAX, REG_CHAR_GAP, REG_BLANK_GAP,
                     REG_BLANK_GAP + 3'd1, REG_BLANK_GAP + 3'd2, REG_BLANK_GAP + 3'd3};
        data_list = '{CFG_W'(deb), CFG_W'(dot), CFG_W'(dash), CFG_W'(cg), CFG_W'(bg),
                      CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data <= data_list[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_deb = deb;
        cur_dot = dot;
        cur_dash = dash;
        cur_cg = cg;
        cur_bg = bg;
        settings_used++;
    endtask

    // mostly well-formed characters at the current thresholds, some key noise
    task automatic random_traffic(input int n);
        int stop;
        int nsym;
        int len;
        int hi;
        int m;
        stop = ticks_sent + n;
        while (ticks_sent < stop)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    key_run($urandom_range(0, 1), $urandom_range(1, 12));
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       nsym = $urandom_range(5, 8);
                    1:       nsym = MAX_SYMBOLS_DEF + 1;
                    default: nsym = $urandom_range(1, 4);
                endcase
                for (int s = 0; s < nsym; s++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        hi = (cur_dot < cur_deb + 6) ? cur_dot : cur_deb + 6;
                        len = (cur_dot > cur_deb) ? $urandom_range(cur_deb + 1, hi)
                                                  : $urandom_range(1, 3);
                    end
                    else
                    begin
                        hi = (cur_dash < cur_dot + 8) ? cur_dash : cur_dot + 8;
                        len = (cur_dash > cur_dot) ? $urandom_range(cur_dot + 1, hi)
                                                   : $urandom_range(1, 4);
                    end
                    key_run(1'b1, len);
                    // space inside a character stays below the character gap
                    hi = (cur_cg < 6) ? cur_cg : 6;
                    if (hi < 1)
                        hi = 1;
                    if (s < nsym - 1)
                        key_run(1'b0, $urandom_range(1, hi));
                end
                m = cur_cg + 1 + $urandom_range(0, 3);
                if (cur_bg < 200 && $urandom_range(0, 3) == 0)
                    m += cur_bg + 1;
                key_run(1'b0, m);
            end
        end
        key_run(1'b0, cur_cg + 2);
    endtask

    initial
    begin : stimulus
        int deb;
        int dot;
        int dash;
        int cg;
        int bg;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: one dot, then the character gap decodes it
        key_run(1'b1, 100);
        key_run(1'b0, 702);

        // directed: bounce, dot, dash, decode, then blank clears the text
        set_timing(1, 3, 6, 4, 7);
        key_run(1'b1, 1);
        key_run(1'b0, 1);
        key_run(1'b1, 2);
        key_run(1'b0, 1);
        key_run(1'b1, 5);
        key_run(1'b0, 5);
        key_run(1'b0, 7);

        for (int p = 0; p < 5; p++)
        begin
            deb = $urandom_range(0, 3);
            dot = deb + $urandom_range(1, 4);
            dash = dot + $urandom_range(1, 6);
            cg = $urandom_range(0, 10);
            case ($urandom_range(0, 2))
                0:       bg = cg;
                1:       bg = $urandom_range(0, cg);
                default: bg = cg + $urandom_range(1, 20);
            endcase
            set_timing(deb, dot, dash, cg, bg);
            // long receiver hold-off while ticks keep coming
            if (p == 0)
                want_hold <= 1'b1;
            random_traffic(70);
        end

        // character and blank gap equal: decode must win
        set_timing(1, 3, 7, 5, 5);
        random_traffic(120);

        // blank never reached: text count runs into its ceiling
        set_timing(0, 1, 65535, 2, 65535);
        random_traffic(500);

        // all thresholds at zero, then all at full scale
        set_timing(0, 0, 0, 0, 0);
        random_traffic(100);
        set_timing(65535, 65535, 65535, 65535, 65535);
        repeat (6)
            key_run($urandom_range(0, 1), $urandom_range(1, 12));
        key_run(1'b0, 2);

        // full store: sixteen dots, a press that is ignored, then a decode error
        set_timing(0, 65534, 65535, 40, 65535);
        repeat (MAX_SYMBOLS_DEF)
        begin
            key_run(1'b1, 2);
            key_run(1'b0, 1);
        end
        key_run(1'b1, 5);
        key_run(1'b0, 42);

        drain();
        repeat (8) @(posedge clk);
        $display("tb_top: %0d key ticks checked across %0d threshold settings", ticks_seen,
                 settings_used);
        $display("tb_top: %0d letters, %0d bad characters, %0d text clears; full store exercised",
                 letters_seen, bad_chars_seen, clears_seen);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
